// File: design/cell_voltage_calibration_stats_macros.svh
// Assertion macros shared by the cell voltage calibration and statistics RTL.
`ifndef CELL_VOLTAGE_CALIBRATION_STATS_MACROS_SVH
`define CELL_VOLTAGE_CALIBRATION_STATS_MACROS_SVH

// Same-cycle implication, checked on i_clk, off while i_rst_n is low
`define CVCS_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("cvcs: implication check failed");

// Next-cycle implication, checked on i_clk, off while i_rst_n is low
`define CVCS_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("cvcs: next-cycle check failed");

`endif

// File: design/cvcs_pkg.sv
// Package: types and constants of the cell voltage calibration and statistics block.
`timescale 1ns / 1ps
package cvcs_pkg;

    localparam logic [15:0] UNITY_Q10         = 16'd1024;
    localparam logic [14:0] MIN_START         = 15'h7FFF;
    localparam logic [31:0] TENTH_Q14         = 32'd1638;
    localparam logic [31:0] OFFSET_SCALE      = 32'd1000;
    localparam int          MAX_CELLS_DEFAULT = 32;
    localparam int          QUEUE_DEPTH       = 2;

    localparam int          CFG_IDX_W         = 8;
    localparam logic [CFG_IDX_W-1:0] CFG_FRONT_GAIN   = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FRONT_OFFSET = 8'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PACK_GAIN    = 8'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_PACK_OFFSET  = 8'd3;

    typedef struct packed {
        logic [15:0]        raw_voltage;
        logic [15:0]        cell_gain;
        logic signed [15:0] cell_offset;
        logic               last_cell;
    } t_in;

    typedef struct packed {
        logic [15:0] cell_voltage;
        logic        summary_valid;
        logic [15:0] max_voltage;
        logic [14:0] min_voltage;
        logic [15:0] voltage_spread;
        logic [5:0]  max_position;
        logic [5:0]  min_position;
        logic [15:0] pack_total;
    } t_out;

    // Calibrated cell passed from the front to the back
    typedef struct packed {
        logic [15:0] volt;
        logic        last;
    } t_cell;

endpackage

// File: design/cvcs_front.sv
// Front: accepts cell readings and calibrates them on a shared gain/offset unit.
`timescale 1ns / 1ps
module cvcs_front (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_stall,
    input  cvcs_pkg::t_in    i_data,
    input  logic [15:0]      i_front_gain,
    input  logic [15:0]      i_front_offset,
    output logic             o_push,
    output cvcs_pkg::t_cell  o_entry,
    input  logic             i_full
);

    localparam logic [1:0] F_IDLE = 2'd0;
    localparam logic [1:0] F_MUL  = 2'd1;
    localparam logic [1:0] F_ADD  = 2'd2;

    logic [1:0]  r_state;
    logic        r_front_pass;
    logic [31:0] r_v;
    logic [15:0] r_k;
    logic [15:0] r_b;
    logic [15:0] r_cg;
    logic [15:0] r_co;
    logic        r_last;
    logic [31:0] r_prod;

    logic        w_accept;
    logic        w_bypass;
    logic [31:0] w_sum;

    // Classify: front stage is skipped when it is at identity
    assign w_bypass = (i_front_gain == cvcs_pkg::UNITY_Q10) && (i_front_offset == 16'd0);
    assign w_accept = i_valid && (r_state == F_IDLE);
    assign o_stall  = (r_state != F_IDLE);

    // Arithmetic shift of the product plus the sign-extended offset
    assign w_sum = {{10{r_prod[31]}}, r_prod[31:10]} + {{16{r_b[15]}}, r_b};

    // Clamp at zero, keep the low half
    assign o_push        = (r_state == F_ADD) && !r_front_pass && !i_full;
    assign o_entry.volt  = w_sum[31] ? 16'd0 : w_sum[15:0];
    assign o_entry.last  = r_last;

    // Sequence one or two passes through the multiplier
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= F_IDLE;
            r_front_pass <= 1'b0;
        end else begin
            case (r_state)
                F_IDLE: begin
                    if (w_accept) begin
                        r_state      <= F_MUL;
                        r_front_pass <= !w_bypass;
                    end
                end
                F_MUL: begin
                    r_state <= F_ADD;
                end
                F_ADD: begin
                    if (r_front_pass) begin
                        r_state      <= F_MUL;
                        r_front_pass <= 1'b0;
                    end else if (!i_full) begin
                        r_state <= F_IDLE;
                    end
                end
                default: begin
                    r_state <= F_IDLE;
                end
            endcase
        end
    end

    // Operand and product registers
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_v    <= {16'd0, i_data.raw_voltage};
            r_k    <= w_bypass ? i_data.cell_gain : i_front_gain;
            r_b    <= w_bypass ? i_data.cell_offset : i_front_offset;
            r_cg   <= i_data.cell_gain;
            r_co   <= i_data.cell_offset;
            r_last <= i_data.last_cell;
        end
        if (r_state == F_MUL) begin
            r_prod <= r_v * {16'd0, r_k};
        end
        if ((r_state == F_ADD) && r_front_pass) begin
            r_v <= w_sum;
            r_k <= r_cg;
            r_b <= r_co;
        end
    end

endmodule

// File: design/cvcs_queue.sv
// Queue: short FIFO of calibrated cells between the front and the back.
`timescale 1ns / 1ps
`include "cell_voltage_calibration_stats_macros.svh"
module cvcs_queue #(
    parameter int DEPTH = cvcs_pkg::QUEUE_DEPTH
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  cvcs_pkg::t_cell  i_entry,
    output logic             o_full,
    input  logic             i_pop,
    output cvcs_pkg::t_cell  o_entry,
    output logic             o_empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    cvcs_pkg::t_cell  r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr;
    logic [PTR_W-1:0] r_rd;
    logic [CNT_W-1:0] r_count;

    assign o_full  = (r_count == CNT_FULL);
    assign o_empty = (r_count == '0);
    assign o_entry = r_mem[r_rd];

    // Advance pointers and count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wr <= (r_wr == PTR_LAST) ? '0 : r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= (r_rd == PTR_LAST) ? '0 : r_rd + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (!i_push && i_pop) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    // Store entries
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_entry;
        end
    end

    `CVCS_ASSERT_IMP(a_no_overflow, i_push, !o_full || i_pop)
    `CVCS_ASSERT_IMP(a_no_underflow, i_pop, !o_empty)

endmodule

// File: design/cvcs_back.sv
// Back: running string statistics, pack total and the result register.
`timescale 1ns / 1ps
`include "cell_voltage_calibration_stats_macros.svh"
module cvcs_back #(
    parameter int MAX_CELLS = cvcs_pkg::MAX_CELLS_DEFAULT
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_empty,
    input  cvcs_pkg::t_cell  i_entry,
    output logic             o_pop,
    input  logic [15:0]      i_pack_gain,
    input  logic [15:0]      i_pack_offset,
    output logic             o_valid,
    input  logic             i_stall,
    output cvcs_pkg::t_out   o_data
);

    localparam int IDX_W = (MAX_CELLS > 1) ? $clog2(MAX_CELLS) : 1;
    localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(MAX_CELLS - 1);

    localparam logic [2:0] B_IDLE  = 3'd0;
    localparam logic [2:0] B_MUL   = 3'd1;
    localparam logic [2:0] B_ADD   = 3'd2;
    localparam logic [2:0] B_SCALE = 3'd3;
    localparam logic [2:0] B_OUT   = 3'd4;

    logic [2:0]       r_state;
    logic [IDX_W-1:0] r_idx;
    logic [15:0]      r_max;
    logic [14:0]      r_min;
    logic [IDX_W-1:0] r_max_idx;
    logic [IDX_W-1:0] r_min_idx;
    logic [20:0]      r_sum;
    logic             r_out_valid;
    cvcs_pkg::t_out   r_out;
    logic [15:0]      r_volt;
    logic [31:0]      r_p1;
    logic [31:0]      r_poff;
    logic [31:0]      r_tot;

    logic             w_out_free;
    logic             w_load_cell;
    logic             w_load_sum;
    logic [15:0]      w_v;
    cvcs_pkg::t_out   n_out;

    assign w_v        = i_entry.volt;
    assign w_out_free = !r_out_valid || !i_stall;
    assign o_pop      = (r_state == B_IDLE) && !i_empty && (i_entry.last || w_out_free);
    assign w_load_cell = o_pop && !i_entry.last;
    assign w_load_sum  = (r_state == B_OUT) && w_out_free;
    assign o_valid    = r_out_valid;
    assign o_data     = r_out;

    // Build the next result: plain cell or string summary
    always_comb begin
        n_out = '0;
        if (w_load_sum) begin
            n_out.cell_voltage   = r_volt;
            n_out.summary_valid  = 1'b1;
            n_out.max_voltage    = r_max;
            n_out.min_voltage    = r_min;
            n_out.voltage_spread = r_max - {1'b0, r_min};
            n_out.max_position   = 6'(r_max_idx) + 6'd1;
            n_out.min_position   = 6'(r_min_idx) + 6'd1;
            n_out.pack_total     = r_tot[29:14];
        end else begin
            n_out.cell_voltage   = w_v;
        end
    end

    // Sequence the summary and keep the statistics
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= B_IDLE;
            r_idx       <= '0;
            r_max       <= '0;
            r_min       <= cvcs_pkg::MIN_START;
            r_max_idx   <= '0;
            r_min_idx   <= '0;
            r_sum       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_out_valid && !i_stall) begin
                r_out_valid <= 1'b0;
            end
            if (w_load_cell || w_load_sum) begin
                r_out_valid <= 1'b1;
            end
            case (r_state)
                B_IDLE: begin
                    if (o_pop) begin
                        r_sum <= r_sum + {5'd0, w_v};
                        if (r_max < w_v) begin
                            r_max     <= w_v;
                            r_max_idx <= r_idx;
                        end
                        if ({1'b0, r_min} > w_v) begin
                            r_min     <= w_v[14:0];
                            r_min_idx <= r_idx;
                        end
                        if (i_entry.last) begin
                            r_state <= B_MUL;
                        end else if (r_idx != IDX_LAST) begin
                            r_idx <= r_idx + 1'b1;
                        end
                    end
                end
                B_MUL: begin
                    r_state <= B_ADD;
                end
                B_ADD: begin
                    r_state <= B_SCALE;
                end
                B_SCALE: begin
                    r_state <= B_OUT;
                end
                B_OUT: begin
                    if (w_out_free) begin
                        r_state   <= B_IDLE;
                        r_idx     <= '0;
                        r_max     <= '0;
                        r_min     <= cvcs_pkg::MIN_START;
                        r_max_idx <= '0;
                        r_min_idx <= '0;
                        r_sum     <= '0;
                    end
                end
                default: begin
                    r_state <= B_IDLE;
                end
            endcase
        end
    end

    // Pack total datapath and result payload
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_volt <= w_v;
        end
        if (r_state == B_MUL) begin
            r_p1   <= {11'd0, r_sum} * {16'd0, i_pack_gain};
            r_poff <= {{16{i_pack_offset[15]}}, i_pack_offset} * cvcs_pkg::OFFSET_SCALE;
        end
        if (r_state == B_ADD) begin
            r_tot <= {10'd0, r_p1[31:10]} + r_poff;
        end
        if (r_state == B_SCALE) begin
            r_tot <= r_tot * cvcs_pkg::TENTH_Q14;
        end
        if (w_load_cell || w_load_sum) begin
            r_out <= n_out;
        end
    end

    `CVCS_ASSERT_IMP(a_no_pop_busy, r_state != B_IDLE, !o_pop)
    `CVCS_ASSERT_NXT(a_clear_after_summary, w_load_sum, (r_idx == '0) && (r_sum == '0) && (r_max == '0))
    `CVCS_ASSERT_IMP(a_pos_order, r_state == B_IDLE, (r_max_idx <= r_idx) && (r_min_idx <= r_idx))

endmodule

// File: design/cell_voltage_calibration_stats.sv
// Top level: configuration registers and the front, queue and back of the block.
`timescale 1ns / 1ps
// Calibrates one raw cell voltage per transfer and emits one result per cell; the
// result for the cell marked last_cell also carries the string's max, min, spread,
// first positions and the scaled pack total, after which the statistics restart.
// The front takes a new cell only once the previous one has left it, after one pass
// through its single shared 32x16 multiplier when the front gain/offset is at
// identity and two passes otherwise. The back retires an ordinary cell straight to
// the result register and a last cell through the pack-total multiply chain; a
// two-entry queue between them absorbs that. Configuration writes are always ready
// and take effect on the next cell; out-of-range indexes are ignored.
module cell_voltage_calibration_stats #(
    parameter int MAX_CELLS = cvcs_pkg::MAX_CELLS_DEFAULT
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    output logic                              o_stall,
    input  cvcs_pkg::t_in                     i_data,
    output logic                              o_valid,
    input  logic                              i_stall,
    output cvcs_pkg::t_out                    o_data,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [cvcs_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [15:0]                       i_cfg_data
);

    logic [15:0]     r_front_gain;
    logic [15:0]     r_front_offset;
    logic [15:0]     r_pack_gain;
    logic [15:0]     r_pack_offset;

    logic            w_push;
    logic            w_pop;
    logic            w_full;
    logic            w_empty;
    cvcs_pkg::t_cell w_front_entry;
    cvcs_pkg::t_cell w_back_entry;

    assign o_cfg_ready = 1'b1;

    // Register file writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_front_gain   <= cvcs_pkg::UNITY_Q10;
            r_front_offset <= '0;
            r_pack_gain    <= cvcs_pkg::UNITY_Q10;
            r_pack_offset  <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                cvcs_pkg::CFG_FRONT_GAIN:   r_front_gain   <= i_cfg_data;
                cvcs_pkg::CFG_FRONT_OFFSET: r_front_offset <= i_cfg_data;
                cvcs_pkg::CFG_PACK_GAIN:    r_pack_gain    <= i_cfg_data;
                cvcs_pkg::CFG_PACK_OFFSET:  r_pack_offset  <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    cvcs_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_data         (i_data),
        .i_front_gain   (r_front_gain),
        .i_front_offset (r_front_offset),
        .o_push         (w_push),
        .o_entry        (w_front_entry),
        .i_full         (w_full)
    );

    cvcs_queue #(
        .DEPTH (cvcs_pkg::QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_entry (w_front_entry),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_entry (w_back_entry),
        .o_empty (w_empty)
    );

    cvcs_back #(
        .MAX_CELLS (MAX_CELLS)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_empty       (w_empty),
        .i_entry       (w_back_entry),
        .o_pop         (w_pop),
        .i_pack_gain   (r_pack_gain),
        .i_pack_offset (r_pack_offset),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_data        (o_data)
    );

endmodule
